>>> rtl/jstc_pkg.sv
// ----------------------------------------------------------------------------
// jstc_pkg
// Shared types and constants for the JSON scalar token classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package jstc_pkg;

  // Recognizer states, one-hot
  typedef enum logic [17:0] {
    ST_START       = 18'h00001,
    ST_NEED_DIGIT  = 18'h00002,
    ST_INT_PART    = 18'h00004,
    ST_AFTER_POINT = 18'h00008,
    ST_FRAC_PART   = 18'h00010,
    ST_EXP_PART    = 18'h00020,
    ST_F_A         = 18'h00040,
    ST_F_L         = 18'h00080,
    ST_F_S         = 18'h00100,
    ST_F_E         = 18'h00200,
    ST_T_R         = 18'h00400,
    ST_T_U         = 18'h00800,
    ST_T_E         = 18'h01000,
    ST_N_U         = 18'h02000,
    ST_N_L1        = 18'h04000,
    ST_N_L2        = 18'h08000,
    ST_TRAIL_WS    = 18'h10000,
    ST_FAILED      = 18'h20000
  } state_t;

  // Token kinds reported on value_kind
  typedef enum logic [2:0] {
    KIND_UNDEF = 3'd0,
    KIND_NULL  = 3'd1,
    KIND_BOOL  = 3'd2,
    KIND_SINT  = 3'd3,
    KIND_UINT  = 3'd4,
    KIND_FLOAT = 3'd5
  } kind_t;

  // Recognizer position after one character
  typedef struct packed {
    state_t state;
    kind_t  kind;
  } step_t;

  localparam logic [7:0] LOWER_BIT = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_POINT  = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_L  = 8'h6c;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_S  = 8'h73;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

endpackage

`default_nettype wire

>>> rtl/jstc_in_if.sv
// ----------------------------------------------------------------------------
// jstc_in_if
// Character request channel: one token byte and a last-byte flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface jstc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

>>> rtl/jstc_out_if.sv
// ----------------------------------------------------------------------------
// jstc_out_if
// Result request channel: the kind of one classified token.
// ----------------------------------------------------------------------------
`default_nettype none

interface jstc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] value_kind;

  modport source (output valid, output value_kind, input ready);
  modport sink   (input valid, input value_kind, output ready);
endinterface

`default_nettype wire

>>> rtl/jstc_step.sv
// ----------------------------------------------------------------------------
// jstc_step
// Next-state logic of the token recognizer for one character.
// ----------------------------------------------------------------------------
`default_nettype none

module jstc_step (
  input  var jstc_pkg::state_t state,
  input  var jstc_pkg::kind_t  kind,
  input  var logic [7:0]       char_code,
  output var jstc_pkg::step_t  nxt
);
  import jstc_pkg::*;

  function automatic state_t word_step(logic [7:0] c, logic [7:0] want, state_t hit);
    return ((c | LOWER_BIT) == want) ? hit : ST_FAILED;
  endfunction

  logic       is_digit;
  logic       is_ws;
  logic [7:0] folded;
  state_t     n;
  kind_t      k;

  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_ws    = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                    (char_code == CH_LF) || (char_code == CH_CR);
  assign folded   = char_code | LOWER_BIT;

  always_comb begin
    n = ST_FAILED;
    k = kind;
    unique case (state)
      ST_START: begin
        n = ST_START;
        if (char_code == CH_MINUS) begin
          k = KIND_SINT;
          n = ST_NEED_DIGIT;
        end else if (is_digit) begin
          k = KIND_UINT;
          n = ST_INT_PART;
        end else if (folded == CH_LOW_F) begin
          n = ST_F_A;
        end else if (folded == CH_LOW_N) begin
          n = ST_N_U;
        end else if (folded == CH_LOW_T) begin
          n = ST_T_R;
        end
      end
      ST_NEED_DIGIT: begin
        if (is_digit) n = ST_INT_PART;
      end
      ST_INT_PART: begin
        if (is_digit) begin
          n = ST_INT_PART;
        end else if (char_code == CH_POINT) begin
          k = KIND_FLOAT;
          n = ST_AFTER_POINT;
        end else if (char_code == CH_LOW_E) begin
          n = ST_EXP_PART;
        end else if (is_ws) begin
          n = ST_TRAIL_WS;
        end
      end
      ST_AFTER_POINT: begin
        if (is_digit) n = ST_FRAC_PART;
      end
      ST_FRAC_PART: begin
        if (is_digit) begin
          n = ST_FRAC_PART;
        end else if (char_code == CH_LOW_E) begin
          n = ST_EXP_PART;
        end else if (is_ws) begin
          n = ST_TRAIL_WS;
        end
      end
      ST_EXP_PART: begin
        if (is_digit) begin
          n = ST_EXP_PART;
        end else if (is_ws) begin
          n = ST_TRAIL_WS;
        end
      end
      ST_F_A: n = word_step(char_code, CH_LOW_A, ST_F_L);
      ST_F_L: n = word_step(char_code, CH_LOW_L, ST_F_S);
      ST_F_S: n = word_step(char_code, CH_LOW_S, ST_F_E);
      ST_F_E: begin
        n = word_step(char_code, CH_LOW_E, ST_TRAIL_WS);
        if (n == ST_TRAIL_WS) k = KIND_BOOL;
      end
      ST_T_R: n = word_step(char_code, CH_LOW_R, ST_T_U);
      ST_T_U: n = word_step(char_code, CH_LOW_U, ST_T_E);
      ST_T_E: begin
        n = word_step(char_code, CH_LOW_E, ST_TRAIL_WS);
        if (n == ST_TRAIL_WS) k = KIND_BOOL;
      end
      ST_N_U:  n = word_step(char_code, CH_LOW_U, ST_N_L1);
      ST_N_L1: n = word_step(char_code, CH_LOW_L, ST_N_L2);
      ST_N_L2: begin
        n = word_step(char_code, CH_LOW_L, ST_TRAIL_WS);
        if (n == ST_TRAIL_WS) k = KIND_NULL;
      end
      ST_TRAIL_WS: begin
        if (is_ws) n = ST_TRAIL_WS;
      end
      default: n = ST_FAILED;
    endcase
    // a failed token reports undefined
    if (n == ST_FAILED) k = KIND_UNDEF;
    nxt.state = n;
    nxt.kind  = k;
  end

endmodule

`default_nettype wire

>>> rtl/json_scalar_token_classifier.sv
// A character request is held in the input stage and classified from there
//   into the recognizer state; a last character loads the result register, held until taken.
// Throughput: one character per cycle, set by one recognizer step; a last character stalls behind an untaken result.
// Reset: synchronous, active low; clears both stages and returns the
//   recognizer to its start state with an undefined kind.
// ----------------------------------------------------------------------------
// json_scalar_token_classifier
// Classifies an unquoted JSON scalar token streamed one byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

module json_scalar_token_classifier (
  input  var logic clk,
  input  var logic rst_n,
  jstc_in_if.sink    in_chan,
  jstc_out_if.source out_chan
);
  import jstc_pkg::*;

  // Input stage: holds one character request
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // Recognizer position between characters of a token
  state_t     state_r;
  kind_t      kind_r;

  // Result stage
  logic       out_valid_r;
  kind_t      out_kind_r;

  step_t      step;
  logic       s1_fire;
  logic       in_fire;
  logic       out_fire;

  jstc_step u_step (
    .state     (state_r),
    .kind      (kind_r),
    .char_code (s1_char_r),
    .nxt       (step)
  );

  assign out_fire = out_valid_r && out_chan.ready;

  // Advance the held character when it makes no result, or the result slot
  // is free or being drained this cycle.
  assign s1_fire = s1_valid_r && (!s1_last_r || !out_valid_r || out_chan.ready);

  // Take a new character whenever the input stage is empty or moving on.
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.value_kind = out_kind_r;

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_chan.char_code;
      s1_last_r <= in_chan.is_last;
    end
  end

  // Recognizer state: advance per character, restart after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      kind_r  <= KIND_UNDEF;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        state_r <= ST_START;
        kind_r  <= KIND_UNDEF;
      end else begin
        state_r <= step.state;
        kind_r  <= step.kind;
      end
    end
  end

  // Result register: load on a last character, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_kind_r <= step.kind;
    end
  end

`ifndef NO_ASSERTIONS
  // The recognizer restarts cleanly after each token's last character.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> state_r == ST_START && kind_r == KIND_UNDEF)
    else $error("recognizer did not restart after last character");

  // A failed token carries no kind.
  a_failed_undef: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FAILED |-> kind_r == KIND_UNDEF)
    else $error("failed state with a defined kind");

  // Ignored leading bytes never record a kind.
  a_start_undef: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_START |-> kind_r == KIND_UNDEF)
    else $error("start state with a defined kind");

  // Exactly one state bit is set.
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("recognizer state not one-hot");

  // A pending result is never overwritten by a later token.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |-> !(s1_fire && s1_last_r))
    else $error("result overwritten while pending");
`endif

endmodule

`default_nettype wire

>>> tb/sv/json_scalar_token_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_scalar_token_classifier_test
// Streams directed and random value tokens byte by byte into the classifier,
// tracks the expected kind of every token on its own and checks the results
// in order, with random gaps on the character side and stalls on the result
// side.
// ----------------------------------------------------------------------------

module json_scalar_token_classifier_test;
  import jstc_pkg::*;

  localparam int CHAR_TARGET    = 1250;  // stop generating once this many bytes are queued
  localparam int WATCHDOG_LIMIT = 500;   // cycles without any request moving
  localparam int SETTLE_CHARS   = 120;   // no idling once fewer bytes than this are left
  localparam int DRAIN_CYCLES   = 4;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_req_t;

  logic clk;
  logic rst_n;

  jstc_in_if  in_chan ();
  jstc_out_if out_chan ();

  json_scalar_token_classifier dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Byte requests still to be driven, bytes of the token under construction,
  // and the kinds the classifier owes us, oldest first.
  char_req_t  pending_chars[$];
  logic [7:0] token_bytes[$];
  kind_t      expected_kinds[$];

  // Shadow of the recognizer, advanced on every accepted byte.
  state_t trk_state;
  kind_t  trk_kind;

  // Driver bookkeeping
  logic      char_taken;
  int        gap_left;
  int        stall_left;
  int        calm_left;
  logic      quiet;
  char_req_t next_req;

  // Scoreboard counters
  int chars_total;
  int chars_sent;
  int tokens_checked;
  int fail_count;
  int kind_seen[6];
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Byte classes
  // --------------------------------------------------------------------------
  function automatic logic is_digit_ch(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_space_ch(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  // Word letters match in either case: folding in the lower-case bit is enough
  // because every letter we look for is already lower case.
  function automatic state_t letter_next(input logic [7:0] c, input logic [7:0] letter,
                                         input state_t hit);
    return ((c | LOWER_BIT) == letter) ? hit : ST_FAILED;
  endfunction

  // Bytes that the start state skips over: anything that opens neither a
  // number nor a word.
  function automatic logic [7:0] ignored_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_MINUS || is_digit_ch(b) || (b | LOWER_BIT) == CH_LOW_F ||
               (b | LOWER_BIT) == CH_LOW_N || (b | LOWER_BIT) == CH_LOW_T);
    return b;
  endfunction

  function automatic logic [7:0] space_byte();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Token kind tracking: advance the shadow recognizer by one accepted byte
  // and, on the last byte, queue the kind that the block must report.
  // --------------------------------------------------------------------------
  function void track_char(input logic [7:0] c, input logic last);
    state_t nx;
    nx = ST_FAILED;
    case (trk_state)
      ST_START: begin
        // Skip everything up to the first byte that can open a token.
        nx = ST_START;
        if (c == CH_MINUS) begin
          trk_kind = KIND_SINT;
          nx = ST_NEED_DIGIT;
        end else if (is_digit_ch(c)) begin
          trk_kind = KIND_UINT;
          nx = ST_INT_PART;
        end else if ((c | LOWER_BIT) == CH_LOW_F) begin
          nx = ST_F_A;
        end else if ((c | LOWER_BIT) == CH_LOW_N) begin
          nx = ST_N_U;
        end else if ((c | LOWER_BIT) == CH_LOW_T) begin
          nx = ST_T_R;
        end
      end
      ST_NEED_DIGIT: if (is_digit_ch(c)) nx = ST_INT_PART;
      ST_INT_PART: begin
        if (is_digit_ch(c)) begin
          nx = ST_INT_PART;
        end else if (c == CH_POINT) begin
          trk_kind = KIND_FLOAT;
          nx = ST_AFTER_POINT;
        end else if (c == CH_LOW_E) begin
          nx = ST_EXP_PART;
        end else if (is_space_ch(c)) begin
          nx = ST_TRAIL_WS;
        end
      end
      ST_AFTER_POINT: if (is_digit_ch(c)) nx = ST_FRAC_PART;
      ST_FRAC_PART: begin
        if (is_digit_ch(c)) nx = ST_FRAC_PART;
        else if (c == CH_LOW_E) nx = ST_EXP_PART;
        else if (is_space_ch(c)) nx = ST_TRAIL_WS;
      end
      // The exponent keeps the kind and takes no sign.
      ST_EXP_PART: begin
        if (is_digit_ch(c)) nx = ST_EXP_PART;
        else if (is_space_ch(c)) nx = ST_TRAIL_WS;
      end
      ST_F_A: nx = letter_next(c, CH_LOW_A, ST_F_L);
      ST_F_L: nx = letter_next(c, CH_LOW_L, ST_F_S);
      ST_F_S: nx = letter_next(c, CH_LOW_S, ST_F_E);
      ST_T_R: nx = letter_next(c, CH_LOW_R, ST_T_U);
      ST_T_U: nx = letter_next(c, CH_LOW_U, ST_T_E);
      ST_N_U: nx = letter_next(c, CH_LOW_U, ST_N_L1);
      ST_N_L1: nx = letter_next(c, CH_LOW_L, ST_N_L2);
      // A word records its kind only once its final letter has matched.
      ST_F_E, ST_T_E: begin
        nx = letter_next(c, CH_LOW_E, ST_TRAIL_WS);
        if (nx == ST_TRAIL_WS) trk_kind = KIND_BOOL;
      end
      ST_N_L2: begin
        nx = letter_next(c, CH_LOW_L, ST_TRAIL_WS);
        if (nx == ST_TRAIL_WS) trk_kind = KIND_NULL;
      end
      ST_TRAIL_WS: if (is_space_ch(c)) nx = ST_TRAIL_WS;
      default: nx = ST_FAILED;  // a failed token stays failed until its last byte
    endcase
    if (nx == ST_FAILED) trk_kind = KIND_UNDEF;
    trk_state = nx;
    if (last) begin
      expected_kinds.push_back(trk_kind);
      trk_state = ST_START;
      trk_kind  = KIND_UNDEF;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Token construction
  // --------------------------------------------------------------------------
  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) token_bytes.push_back(s[i]);
  endtask

  task automatic push_digits(input int n);
    repeat (n) token_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_number();
    if ($urandom_range(0, 1)) token_bytes.push_back(CH_MINUS);
    push_digits($urandom_range(1, 4));
    if ($urandom_range(0, 9) < 4) begin
      token_bytes.push_back(CH_POINT);
      push_digits($urandom_range(1, 3));
    end
    if ($urandom_range(0, 9) < 3) begin
      token_bytes.push_back(CH_LOW_E);
      push_digits($urandom_range(1, 2));
    end
  endtask

  // Spell one of the three words, each letter in a random case.
  task automatic push_word();
    string w;
    int    i;
    case ($urandom_range(0, 2))
      0: w = "true";
      1: w = "false";
      default: w = "null";
    endcase
    for (i = 0; i < w.len(); i++) begin
      token_bytes.push_back($urandom_range(0, 1) ? (w[i] & ~LOWER_BIT) : w[i]);
    end
  endtask

  // Move the token under construction into the request queue, flagging its
  // final byte.
  task automatic commit_token();
    char_req_t r;
    int        i;
    for (i = 0; i < token_bytes.size(); i++) begin
      r.code = token_bytes[i];
      r.last = (i == token_bytes.size() - 1);
      pending_chars.push_back(r);
    end
    token_bytes.delete();
  endtask

  task automatic build_directed_tokens();
    token_bytes.push_back(8'h00);  // lowest byte, skipped, then a lone minus
    push_text("-");
    commit_token();
    push_text("9");
    commit_token();
    push_text("1.");               // early end after the point: float
    commit_token();
    push_text("1e");               // early end in the exponent: still unsigned
    commit_token();
    push_text("tRuE");
    commit_token();
    push_text("NuLl");
    commit_token();
    push_text("fAlse");
    commit_token();
    push_text("tru");              // unfinished word
    commit_token();
    token_bytes.push_back(8'hff);  // highest byte only: nothing ever starts
    commit_token();
    push_text("1e-");              // signed exponent fails
    commit_token();
  endtask

  // Mostly well-formed numbers and words with random content; the rest are
  // corrupted, cut short, padded or pure noise.
  task automatic build_random_tokens();
    int shape;
    int pos;
    while (pending_chars.size() < CHAR_TARGET) begin
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) token_bytes.push_back(ignored_byte());
      shape = $urandom_range(0, 99);
      if (shape < 45) begin
        push_number();
      end else if (shape < 75) begin
        push_word();
      end else if (shape < 88) begin
        if ($urandom_range(0, 1)) push_number();
        else push_word();
        pos = $urandom_range(0, token_bytes.size() - 1);
        token_bytes[pos] = 8'($urandom_range(0, 255));
      end else begin
        repeat ($urandom_range(1, 6)) token_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0 && token_bytes.size() > 1) begin
        repeat ($urandom_range(1, token_bytes.size() - 1)) void'(token_bytes.pop_back());
      end else if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 2)) token_bytes.push_back(space_byte());
      end
      if ($urandom_range(0, 19) == 0) token_bytes.push_back(8'($urandom_range(0, 255)));
      commit_token();
    end
  endtask

  function void note_failure(input string what, input int want, input int got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t ns: %s: expected kind %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: change inputs on the falling edge. Hold a byte request until it
  // is taken, then either idle for a short burst or present the next one.
  // Drop the result ready in bursts as well. Idling stops during calm
  // stretches and for the last part of the run.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid  <= 1'b0;
      out_chan.ready <= 1'b0;
    end else begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
      quiet = (pending_chars.size() < SETTLE_CHARS) || (calm_left > 0);

      if (!in_chan.valid || char_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (pending_chars.size() == 0) begin
          in_chan.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 4);  // idle now, then until gap_left has counted down
          in_chan.valid <= 1'b0;
        end else begin
          next_req = pending_chars.pop_front();
          in_chan.char_code <= next_req.code;
          in_chan.is_last   <= next_req.last;
          in_chan.valid     <= 1'b1;
        end
      end

      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample on the rising edge. Track accepted bytes first so that a
  // result never overtakes the expectation of its own token.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    kind_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        track_char(in_chan.char_code, in_chan.is_last);
        chars_sent++;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_kinds.size() == 0) begin
          note_failure("result with no token outstanding", -1, int'(out_chan.value_kind));
        end else begin
          want = expected_kinds.pop_front();
          tokens_checked++;
          kind_seen[int'(want)]++;
          if (out_chan.value_kind !== want) begin
            note_failure("kind mismatch", int'(want), int'(out_chan.value_kind));
          end
        end
      end
    end
    char_taken <= rst_n && in_chan.valid && in_chan.ready;
  end

  // Watchdog: give up when no request moves on either channel for too long.
  initial begin
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no request moved for %0d cycles, %0d of %0d bytes sent, %0d kinds owed",
             WATCHDOG_LIMIT, chars_sent, chars_total, expected_kinds.size());
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence: build all stimulus, hold reset, wait for every byte to go
  // in and every kind to come back, then report.
  // --------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.char_code = '0;
    in_chan.is_last   = 1'b0;
    out_chan.ready    = 1'b0;
    trk_state         = ST_START;
    trk_kind          = KIND_UNDEF;
    char_taken        = 1'b0;
    gap_left          = 0;
    stall_left        = 0;
    calm_left         = 0;
    chars_sent        = 0;
    tokens_checked    = 0;
    fail_count        = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;

    build_directed_tokens();
    build_random_tokens();
    chars_total = pending_chars.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Advance until every byte is in and every owed kind has arrived.
    do @(negedge clk); while (chars_sent < chars_total || expected_kinds.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d bytes forming %0d tokens; %0d results checked, %0d failures",
             chars_sent, tokens_checked, tokens_checked, fail_count);
    $display("Kinds seen: undefined %0d, null %0d, boolean %0d, signed %0d, unsigned %0d, float %0d",
             kind_seen[KIND_UNDEF], kind_seen[KIND_NULL], kind_seen[KIND_BOOL],
             kind_seen[KIND_SINT], kind_seen[KIND_UINT], kind_seen[KIND_FLOAT]);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/jstc_pkg.sv
rtl/jstc_in_if.sv
rtl/jstc_out_if.sv
rtl/jstc_step.sv
rtl/json_scalar_token_classifier.sv
tb/sv/json_scalar_token_classifier_test.sv
